### hdl/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    // Command broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_POP    = 2'd2
    } t_cmd;

    // Result status codes
    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_FULL      = 2'd1,
        STS_UNDERFLOW = 2'd2
    } t_status;

    // Input operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    // Width of the saturating leaf counter
    localparam int LEAF_W = 16;

    // Field widths of the tuser buses
    localparam int S_USER_W = 2;
    localparam int M_USER_W = 2;

endpackage
`default_nettype wire

### hdl/spq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry and, on each command, keeps it,
// takes the entry from its left neighbor, takes the new entry, or takes the
// entry two places to its right.
// ----------------------------------------------------------------------------
module spq_cell #(
    parameter int PRIO_W = 24,
    parameter int TAG_W  = 9
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire spq_pkg::t_cmd  i_cmd,
    input  wire  [PRIO_W-1:0]   i_new_prio,
    input  wire  [TAG_W-1:0]    i_new_tag,
    input  wire                 i_left_valid,
    input  wire  [PRIO_W-1:0]   i_left_prio,
    input  wire  [TAG_W-1:0]    i_left_tag,
    input  wire                 i_left_behind,
    input  wire                 i_far_valid,
    input  wire  [PRIO_W-1:0]   i_far_prio,
    input  wire  [TAG_W-1:0]    i_far_tag,
    output logic                o_valid,
    output logic [PRIO_W-1:0]   o_prio,
    output logic [TAG_W-1:0]    o_tag,
    output logic                o_behind
);

    logic              r_valid;
    logic [PRIO_W-1:0] r_prio;
    logic [TAG_W-1:0]  r_tag;
    logic              n_valid;
    logic [PRIO_W-1:0] n_prio;
    logic [TAG_W-1:0]  n_tag;
    logic              w_behind;

    // Entry sits at or behind the insert point: empty, or not smaller than new
    assign w_behind = !r_valid || (r_prio >= i_new_prio);

    // Select next slot contents
    always_comb begin
        n_valid = r_valid;
        n_prio  = r_prio;
        n_tag   = r_tag;
        case (i_cmd)
            spq_pkg::CMD_INSERT: begin
                if (w_behind) begin
                    if (i_left_behind) begin
                        n_valid = i_left_valid;
                        n_prio  = i_left_prio;
                        n_tag   = i_left_tag;
                    end else begin
                        n_valid = 1'b1;
                        n_prio  = i_new_prio;
                        n_tag   = i_new_tag;
                    end
                end
            end
            spq_pkg::CMD_POP: begin
                n_valid = i_far_valid;
                n_prio  = i_far_prio;
                n_tag   = i_far_tag;
            end
            default: begin
                n_valid = r_valid;
            end
        endcase
    end

    // Hold valid flag, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Hold payload
    always_ff @(posedge i_clk) begin
        r_prio <= n_prio;
        r_tag  <= n_tag;
    end

    assign o_valid  = r_valid;
    assign o_prio   = r_prio;
    assign o_tag    = r_tag;
    assign o_behind = w_behind;

endmodule
`default_nettype wire

### hdl/sorted_priority_queue_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Ascending priority queue built as a chain of slot cells. Insert places an
// item ahead of the first entry with equal or greater priority; pop drops the
// two front entries. Each item returns one result with the front two entries,
// occupancy, a saturating leaf count and status.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake              tuser (low bit up)     tdata (low bit up)
//  s_axis   in   s_axis_tvalid/tready   op, is_leaf            priority_req, tag
//  m_axis   out  m_axis_tvalid/tready   status                 first_priority,
//                                                              first_tag,
//                                                              second_priority,
//                                                              second_tag,
//                                                              occupancy,
//                                                              leaves_seen,
//                                                              empty_res
//
//  Rate: one item per cycle while results are taken; every cell compares
//  and shifts in parallel, so the result is shown the cycle after acceptance.
//  The front cells and the counters are the output register: a new item is
//  taken in the same cycle its predecessor's result is taken.
//  Stalls: while a result waits on m_axis_tready, s_axis_tready stays low.
//  Reset: synchronous, clears every slot valid flag, the counters and the
//  result valid; slot payload is not reset.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit #(
    parameter int DEPTH         = 256,
    parameter int PRIORITY_BITS = 24,
    parameter int TAG_BITS      = 9,
    localparam int CNT_W        = $clog2(DEPTH + 1),
    localparam int S_FIELD_W    = PRIORITY_BITS + TAG_BITS,
    localparam int S_DATA_W     = ((S_FIELD_W + 7) / 8) * 8,
    localparam int M_FIELD_W    = 2 * PRIORITY_BITS + 2 * TAG_BITS + CNT_W
                                  + spq_pkg::LEAF_W + 1,
    localparam int M_DATA_W     = ((M_FIELD_W + 7) / 8) * 8
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    // priority_req, tag
    input  wire  [S_DATA_W-1:0]              s_axis_tdata,
    // op, is_leaf
    input  wire  [spq_pkg::S_USER_W-1:0]     s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // first_priority, first_tag, second_priority, second_tag, occupancy,
    // leaves_seen, empty_res
    output logic [M_DATA_W-1:0]              m_axis_tdata,
    // status
    output logic [spq_pkg::M_USER_W-1:0]     m_axis_tuser
);

    // Output field offsets
    localparam int O_FTAG  = PRIORITY_BITS;
    localparam int O_SPRI  = O_FTAG + TAG_BITS;
    localparam int O_STAG  = O_SPRI + PRIORITY_BITS;
    localparam int O_OCC   = O_STAG + TAG_BITS;
    localparam int O_LEAF  = O_OCC + CNT_W;
    localparam int O_EMPTY = O_LEAF + spq_pkg::LEAF_W;

    logic                         w_accept;
    logic                         w_op;
    logic                         w_is_leaf;
    logic [PRIORITY_BITS-1:0]     w_new_prio;
    logic [TAG_BITS-1:0]          w_new_tag;
    logic                         w_full;
    logic                         w_short;
    spq_pkg::t_cmd                w_cmd;

    logic                         r_out_valid;
    spq_pkg::t_status             r_status;
    logic [CNT_W-1:0]             r_count;
    logic [spq_pkg::LEAF_W-1:0]   r_leaf;
    logic                         n_out_valid;
    spq_pkg::t_status             n_status;
    logic [CNT_W-1:0]             n_count;
    logic [spq_pkg::LEAF_W-1:0]   n_leaf;

    logic [DEPTH-1:0]             w_valid;
    logic [DEPTH-1:0]             w_behind;
    logic [PRIORITY_BITS-1:0]     w_prio [DEPTH];
    logic [TAG_BITS-1:0]          w_tag  [DEPTH];

    // Unpack input item
    assign w_op       = s_axis_tuser[0];
    assign w_is_leaf  = s_axis_tuser[1];
    assign w_new_prio = s_axis_tdata[PRIORITY_BITS-1:0];
    assign w_new_tag  = s_axis_tdata[S_FIELD_W-1:PRIORITY_BITS];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_full        = (r_count == CNT_W'(DEPTH));
    assign w_short       = (r_count < CNT_W'(2));

    // Decode chain command and next counters
    always_comb begin
        w_cmd       = spq_pkg::CMD_HOLD;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_status    = r_status;
        n_count     = r_count;
        n_leaf      = r_leaf;
        if (w_accept) begin
            n_out_valid = 1'b1;
            if (w_op == spq_pkg::OP_INSERT) begin
                if (w_full) begin
                    n_status = spq_pkg::STS_FULL;
                end else begin
                    w_cmd    = spq_pkg::CMD_INSERT;
                    n_status = spq_pkg::STS_OK;
                    n_count  = r_count + CNT_W'(1);
                    if (w_is_leaf && (r_leaf != '1)) begin
                        n_leaf = r_leaf + spq_pkg::LEAF_W'(1);
                    end
                end
            end else begin
                if (w_short) begin
                    n_status = spq_pkg::STS_UNDERFLOW;
                end else begin
                    w_cmd    = spq_pkg::CMD_POP;
                    n_status = spq_pkg::STS_OK;
                    n_count  = r_count - CNT_W'(2);
                end
            end
        end
    end

    // Hold result valid, status and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_status    <= spq_pkg::STS_OK;
            r_count     <= '0;
            r_leaf      <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_status    <= n_status;
            r_count     <= n_count;
            r_leaf      <= n_leaf;
        end
    end

    // Chain of slot cells
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic                     w_lv;
        logic [PRIORITY_BITS-1:0] w_lp;
        logic [TAG_BITS-1:0]      w_lt;
        logic                     w_lb;
        logic                     w_fv;
        logic [PRIORITY_BITS-1:0] w_fp;
        logic [TAG_BITS-1:0]      w_ft;

        if (gi == 0) begin : g_head
            assign w_lv = 1'b0;
            assign w_lp = '0;
            assign w_lt = '0;
            assign w_lb = 1'b0;
        end else begin : g_left
            assign w_lv = w_valid[gi-1];
            assign w_lp = w_prio[gi-1];
            assign w_lt = w_tag[gi-1];
            assign w_lb = w_behind[gi-1];
        end

        if (gi + 2 < DEPTH) begin : g_far
            assign w_fv = w_valid[gi+2];
            assign w_fp = w_prio[gi+2];
            assign w_ft = w_tag[gi+2];
        end else begin : g_tail
            assign w_fv = 1'b0;
            assign w_fp = '0;
            assign w_ft = '0;
        end

        spq_cell #(
            .PRIO_W (PRIORITY_BITS),
            .TAG_W  (TAG_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (w_cmd),
            .i_new_prio    (w_new_prio),
            .i_new_tag     (w_new_tag),
            .i_left_valid  (w_lv),
            .i_left_prio   (w_lp),
            .i_left_tag    (w_lt),
            .i_left_behind (w_lb),
            .i_far_valid   (w_fv),
            .i_far_prio    (w_fp),
            .i_far_tag     (w_ft),
            .o_valid       (w_valid[gi]),
            .o_prio        (w_prio[gi]),
            .o_tag         (w_tag[gi]),
            .o_behind      (w_behind[gi])
        );
    end

    // Pack result item from the front cells and counters
    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[O_FTAG-1:0]         = w_valid[0] ? w_prio[0] : '0;
        m_axis_tdata[O_SPRI-1:O_FTAG]    = w_valid[0] ? w_tag[0]  : '0;
        m_axis_tdata[O_STAG-1:O_SPRI]    = w_valid[1] ? w_prio[1] : '0;
        m_axis_tdata[O_OCC-1:O_STAG]     = w_valid[1] ? w_tag[1]  : '0;
        m_axis_tdata[O_LEAF-1:O_OCC]     = r_count;
        m_axis_tdata[O_EMPTY-1:O_LEAF]   = r_leaf;
        m_axis_tdata[O_EMPTY]            = (r_count == '0);
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_status;

    // Occupancy always equals the number of valid cells
    a_count_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("occupancy does not match valid cells");

    // Front two entries stay in ascending order
    a_front_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[1] |-> (w_prio[0] <= w_prio[1]))
        else $error("front entries out of order");

    // Accepted insert into a non-full queue grows it by one
    a_insert_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_op == spq_pkg::OP_INSERT) && !w_full)
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow occupancy");

    // Rejected operations leave the slot chain untouched
    a_reject_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (n_status != spq_pkg::STS_OK)) |=> $stable(w_valid))
        else $error("rejected item changed the queue");

    // Result stays pending until taken
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(r_count)))
        else $error("pending result changed");

endmodule
`default_nettype wire
